FILE: design/frt_pkg.sv
// frt_pkg: shared types, constants and helper functions of the fragment reassembly tracker
// no dependencies
package frt_pkg;

  localparam int FragmentSlots = 65536;
  localparam int MaxSubpackets = 32;

  localparam int SlotW     = $clog2(FragmentSlots);
  localparam int StotW     = $clog2(MaxSubpackets + 1);
  localparam int SidxW     = (MaxSubpackets > 1) ? $clog2(MaxSubpackets) : 1;
  localparam int PopChunks = (MaxSubpackets + 7) / 8;

  localparam logic [7:0] MsgBcast = 8'd5;
  localparam logic [7:0] MsgSem   = 8'd6;
  localparam logic [7:0] MsgUcast = 8'd7;

  localparam logic [15:0] SizeMin   = 16'd4;
  localparam logic [15:0] SizeBcast = 16'd5;
  localparam logic [15:0] SizeUcast = 16'd7;

  typedef enum logic [3:0] {
    STAT_SHORT      = 4'd0,
    STAT_OTHER_TYPE = 4'd1,
    STAT_HDR_SHORT  = 4'd2,
    STAT_NOT_ADDR   = 4'd3,
    STAT_SEMANTIC   = 4'd4,
    STAT_BAD_SUB    = 4'd5,
    STAT_ALREADY    = 4'd6,
    STAT_RECORDED   = 4'd7,
    STAT_COMPLETED  = 4'd8,
    STAT_MERGE      = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_DATA,
    CMD_MERGE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } back_state_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] packet_size;
    logic [7:0]  msg_type;
    logic [7:0]  hdr_byte1;
    logic [7:0]  hdr_byte2;
    logic [7:0]  hdr_byte3;
    logic [7:0]  hdr_byte4;
    logic [7:0]  hdr_byte5;
    logic [7:0]  hdr_byte6;
    logic [15:0] coop_fragment;
    logic        coop_last;
  } pkt_t;

  typedef struct packed {
    cmd_kind_e        kind;
    status_e          status;
    logic [15:0]      frag;
    logic [SidxW-1:0] sidx;
    logic [StotW-1:0] stot;
    logic             inc_acc;
    logic             inc_sem;
    logic             inc_sub;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic                     distinct;
    logic                     done;
    logic [MaxSubpackets-1:0] map;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] frag;
    logic [16:0] gain;
    logic [31:0] rx_total;
    logic [31:0] semantic_count;
    logic [31:0] data_sub_count;
    logic [31:0] coop_gain_total;
    logic [31:0] coop_round_count;
  } res_t;

  function automatic logic [StotW-1:0] popcount(input logic [MaxSubpackets-1:0] v);
    logic [PopChunks*8-1:0] padded;
    logic [StotW-1:0]       total;
    logic [3:0]             part;
    padded = '0;
    padded[MaxSubpackets-1:0] = v;
    total = '0;
    for (int c = 0; c < PopChunks; c++) begin
      part = '0;
      for (int b = 0; b < 8; b++) begin
        part = part + 4'(padded[c*8+b]);
      end
      total = total + StotW'(part);
    end
    return total;
  endfunction

endpackage

FILE: design/frt_front.sv
// frt_front: classifies packet headers and merge items into commands
// holds a two-entry command queue toward the back end; uses frt_pkg
module frt_front
  import frt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pkt_t        pkt_i,
  input  logic [15:0] node_address_i,
  output logic        queue_full_o,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       cmd_new;
  logic [7:0] sidx8;
  logic [7:0] stot8;
  logic       is_ucast;

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign is_ucast = (pkt_i.msg_type == MsgUcast);

  always_comb begin
    cmd_new.kind    = CMD_REPORT;
    cmd_new.status  = STAT_SHORT;
    cmd_new.frag    = '0;
    cmd_new.sidx    = '0;
    cmd_new.stot    = '0;
    cmd_new.inc_acc = 1'b0;
    cmd_new.inc_sem = 1'b0;
    cmd_new.inc_sub = 1'b0;
    cmd_new.last    = 1'b0;
    sidx8 = pkt_i.hdr_byte3;
    stot8 = pkt_i.hdr_byte4;
    priority if (pkt_i.operation) begin
      cmd_new.kind = CMD_MERGE;
      cmd_new.frag = pkt_i.coop_fragment;
      cmd_new.last = pkt_i.coop_last;
    end else if (pkt_i.packet_size < SizeMin) begin
      cmd_new.status = STAT_SHORT;
    end else if (pkt_i.msg_type != MsgBcast && pkt_i.msg_type != MsgSem && !is_ucast) begin
      cmd_new.status = STAT_OTHER_TYPE;
    end else if (is_ucast && pkt_i.packet_size < SizeUcast) begin
      cmd_new.status = STAT_HDR_SHORT;
    end else if (is_ucast && {pkt_i.hdr_byte2, pkt_i.hdr_byte1} != node_address_i) begin
      cmd_new.status = STAT_NOT_ADDR;
    end else begin
      cmd_new.inc_acc = 1'b1;
      if (is_ucast) begin
        cmd_new.frag = {pkt_i.hdr_byte4, pkt_i.hdr_byte3};
        sidx8 = pkt_i.hdr_byte5;
        stot8 = pkt_i.hdr_byte6;
      end else begin
        cmd_new.frag = {pkt_i.hdr_byte2, pkt_i.hdr_byte1};
      end
      priority if (pkt_i.msg_type == MsgSem) begin
        cmd_new.inc_sem = 1'b1;
        cmd_new.status  = STAT_SEMANTIC;
      end else if (!is_ucast && pkt_i.packet_size < SizeBcast) begin
        cmd_new.status = STAT_HDR_SHORT;
      end else if (stot8 == 8'd0 || stot8 > 8'(MaxSubpackets) || sidx8 >= stot8) begin
        cmd_new.status = STAT_BAD_SUB;
      end else begin
        cmd_new.inc_sub = 1'b1;
        cmd_new.kind    = CMD_DATA;
        cmd_new.sidx    = sidx8[SidxW-1:0];
        cmd_new.stot    = stot8[StotW-1:0];
      end
    end
  end

  assign queue_full_o = (count_q == 2'd2);
  assign cmd_valid_o  = (count_q != 2'd0);
  assign cmd_o        = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (cmd_pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, cmd_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: design/frt_back.sv
// frt_back: per-fragment state memory, read-modify-write sequencer and counters
// clears the memory after reset; consumes commands from frt_front; uses frt_pkg
module frt_back
  import frt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o,
  output logic clearing_o
);

  localparam logic [SlotW-1:0] SlotLast = SlotW'(FragmentSlots - 1);

  entry_t mem_q [FragmentSlots];
  entry_t rdata_q;

  back_state_e state_q, state_d;
  logic [SlotW-1:0] clr_cnt_q, clr_cnt_d;
  cmd_t cmd_q;

  logic [31:0] rx_q, rx_d;
  logic [31:0] sem_q, sem_d;
  logic [31:0] sub_q, sub_d;
  logic [31:0] coop_total_q, coop_total_d;
  logic [31:0] coop_round_q, coop_round_d;
  logic [16:0] gain_acc_q, gain_acc_d;

  logic                     start;
  logic                     mem_re;
  logic                     mem_we;
  logic [SlotW-1:0]         mem_waddr;
  entry_t                   mem_wdata;
  logic [MaxSubpackets-1:0] new_map;
  logic [16:0]              gain_next;

  assign start      = (state_q == ST_IDLE) && cmd_valid_i && !res_full_i;
  assign clearing_o = (state_q == ST_CLEAR);
  assign new_map    = rdata_q.map | (MaxSubpackets'(1) << cmd_q.sidx);
  assign gain_next  = gain_acc_q + 17'(!rdata_q.distinct);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_cnt_q == SlotLast) state_d = ST_IDLE;
      ST_IDLE:   if (start) state_d = ST_MODIFY;
      ST_MODIFY: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_pop_o    = start;
    mem_re       = start;
    mem_we       = 1'b0;
    mem_waddr    = cmd_q.frag[SlotW-1:0];
    mem_wdata    = rdata_q;
    clr_cnt_d    = clr_cnt_q;
    res_push_o   = 1'b0;
    rx_d         = rx_q;
    sem_d        = sem_q;
    sub_d        = sub_q;
    coop_total_d = coop_total_q;
    coop_round_d = coop_round_q;
    gain_acc_d   = gain_acc_q;
    res_o.status = cmd_q.status;
    res_o.frag   = cmd_q.frag;
    res_o.gain   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + SlotW'(1);
      end
      ST_MODIFY: begin
        rx_d  = rx_q + 32'(cmd_q.inc_acc);
        sem_d = sem_q + 32'(cmd_q.inc_sem);
        sub_d = sub_q + 32'(cmd_q.inc_sub);
        unique case (cmd_q.kind)
          CMD_DATA: begin
            res_push_o = 1'b1;
            if (rdata_q.done) begin
              res_o.status = STAT_ALREADY;
            end else if (popcount(new_map) >= cmd_q.stot) begin
              mem_we             = 1'b1;
              mem_wdata.distinct = 1'b1;
              mem_wdata.done     = 1'b1;
              mem_wdata.map      = '0;
              res_o.status       = STAT_COMPLETED;
            end else begin
              mem_we        = 1'b1;
              mem_wdata.map = new_map;
              res_o.status  = STAT_RECORDED;
            end
          end
          CMD_MERGE: begin
            mem_we             = !rdata_q.distinct;
            mem_wdata.distinct = 1'b1;
            gain_acc_d         = gain_next;
            if (cmd_q.last) begin
              res_push_o   = 1'b1;
              res_o.status = STAT_MERGE;
              res_o.gain   = gain_next;
              gain_acc_d   = '0;
              if (gain_next != 17'd0) begin
                coop_total_d = coop_total_q + 32'(gain_next);
                coop_round_d = coop_round_q + 32'd1;
              end
            end
          end
          default: begin
            res_push_o = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
    res_o.rx_total         = rx_d;
    res_o.semantic_count   = sem_d;
    res_o.data_sub_count   = sub_d;
    res_o.coop_gain_total  = coop_total_d;
    res_o.coop_round_count = coop_round_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[cmd_i.frag[SlotW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      rx_q         <= '0;
      sem_q        <= '0;
      sub_q        <= '0;
      coop_total_q <= '0;
      coop_round_q <= '0;
      gain_acc_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      rx_q         <= rx_d;
      sem_q        <= sem_d;
      sub_q        <= sub_d;
      coop_total_q <= coop_total_d;
      coop_round_q <= coop_round_d;
      gain_acc_q   <= gain_acc_d;
    end
  end

endmodule

FILE: design/frt_result_fifo.sv
// frt_result_fifo: two-entry queue of finished results toward the output side
// uses frt_pkg
module frt_result_fifo
  import frt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t data_o
);

  res_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: design/fragment_reassembly_tracker.sv
// fragment_reassembly_tracker: top level with the node address register port
// depends on frt_pkg, frt_front, frt_back and frt_result_fifo
//
// Input side is a queue: drive the item fields and raise push; the transaction
// completes on a clock edge with push high and full low. Result side is a queue
// too: while empty is low the oldest result is on the result ports, and it is
// taken on an edge with pop high. Packet items always give one result, merge
// items only when coop_last is set.
// In the back end an item's per-fragment entry is read from the state memory
// in ST_IDLE and updated with the counters in ST_MODIFY; no new item is taken
// until that update is done. Results reach the ports through the result queue.
// Two-entry queues sit at the command and result boundaries; when the receiver
// stalls, results collect there, then the back end holds and full rises.
// After reset the state memory is cleared one slot per cycle, all 65536 slots,
// with full held high; node_address writes are taken during that pass.
// node_address is written over the APB port at byte address 0; the user must
// write it only while idle, which the block itself does not enforce.
module fragment_reassembly_tracker
  import frt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [15:0] packet_size_i,
  input  logic [7:0]  msg_type_i,
  input  logic [7:0]  hdr_byte1_i,
  input  logic [7:0]  hdr_byte2_i,
  input  logic [7:0]  hdr_byte3_i,
  input  logic [7:0]  hdr_byte4_i,
  input  logic [7:0]  hdr_byte5_i,
  input  logic [7:0]  hdr_byte6_i,
  input  logic [15:0] coop_fragment_i,
  input  logic        coop_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status_o,
  output logic [15:0] fragment_id_o,
  output logic [16:0] merge_gain_o,
  output logic [31:0] rx_total_o,
  output logic [31:0] semantic_count_o,
  output logic [31:0] data_sub_count_o,
  output logic [31:0] coop_gain_total_o,
  output logic [31:0] coop_round_count_o
);

  logic [15:0] node_q, node_d;
  pkt_t        pkt;
  logic        accept;
  logic        queue_full;
  logic        clearing;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  logic        res_push;
  logic        res_full;
  res_t        res_in;
  res_t        res_out;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, node_q};
  assign node_d = (psel && penable && pwrite && !paddr[2]) ? pwdata[15:0] : node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= '0;
    end else begin
      node_q <= node_d;
    end
  end

  assign pkt.operation     = operation_i;
  assign pkt.packet_size   = packet_size_i;
  assign pkt.msg_type      = msg_type_i;
  assign pkt.hdr_byte1     = hdr_byte1_i;
  assign pkt.hdr_byte2     = hdr_byte2_i;
  assign pkt.hdr_byte3     = hdr_byte3_i;
  assign pkt.hdr_byte4     = hdr_byte4_i;
  assign pkt.hdr_byte5     = hdr_byte5_i;
  assign pkt.hdr_byte6     = hdr_byte6_i;
  assign pkt.coop_fragment = coop_fragment_i;
  assign pkt.coop_last     = coop_last_i;

  assign full   = queue_full || clearing;
  assign accept = push && !full;

  frt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (accept),
    .pkt_i          (pkt),
    .node_address_i (node_q),
    .queue_full_o   (queue_full),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  frt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  frt_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop && !empty),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign status_o           = res_out.status;
  assign fragment_id_o      = res_out.frag;
  assign merge_gain_o       = res_out.gain;
  assign rx_total_o         = res_out.rx_total;
  assign semantic_count_o   = res_out.semantic_count;
  assign data_sub_count_o   = res_out.data_sub_count;
  assign coop_gain_total_o  = res_out.coop_gain_total;
  assign coop_round_count_o = res_out.coop_round_count;

endmodule

FILE: tb/sv/frt_reassembly_checker.sv
// frt_reassembly_checker: watches the item, result and register channels of the
// fragment reassembly tracker, predicts each result and compares it field by field
// depends on frt_pkg
`timescale 1ns / 1ps

module frt_reassembly_checker
  import frt_pkg::*;
#(
  parameter logic [2:0] NodeAddrOffset = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  pkt_t        item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [3:0]  status_i,
  input  logic [15:0] fragment_id_i,
  input  logic [16:0] merge_gain_i,
  input  logic [31:0] rx_total_i,
  input  logic [31:0] semantic_count_i,
  input  logic [31:0] data_sub_count_i,
  input  logic [31:0] coop_gain_total_i,
  input  logic [31:0] coop_round_count_i,
  output int          fail_count_o,
  output int          pending_count_o
);

  logic [MaxSubpackets-1:0] arrival_bits [FragmentSlots];
  bit                       direct_done [FragmentSlots];
  bit                       distinct_seen [FragmentSlots];

  logic [31:0] accepted_pkts;
  logic [31:0] semantic_pkts;
  logic [31:0] valid_subs;
  logic [31:0] coop_total;
  logic [31:0] coop_rounds;
  logic [16:0] merge_acc;
  logic [15:0] node_addr;

  res_t pending_reports[$];

  function automatic bit track_reassembly(input pkt_t it, output res_t rep);
    int          slot;
    int          ones;
    bit          ucast;
    logic [15:0] fid;
    logic [16:0] gain;
    logic [7:0]  sidx;
    logic [7:0]  stot;
    status_e     st;
    rep  = '0;
    fid  = '0;
    gain = '0;
    if (it.operation) begin
      slot = int'(it.coop_fragment) % FragmentSlots;
      if (!distinct_seen[slot]) begin
        distinct_seen[slot] = 1'b1;
        merge_acc = merge_acc + 17'd1;
      end
      if (!it.coop_last) return 1'b0;
      gain = merge_acc;
      if (gain != '0) begin
        coop_total  = coop_total + 32'(gain);
        coop_rounds = coop_rounds + 32'd1;
      end
      merge_acc = '0;
      st  = STAT_MERGE;
      fid = it.coop_fragment;
    end else begin
      ucast = (it.msg_type == MsgUcast);
      if (it.packet_size < SizeMin) begin
        st = STAT_SHORT;
      end else if (it.msg_type != MsgBcast && it.msg_type != MsgSem && !ucast) begin
        st = STAT_OTHER_TYPE;
      end else if (ucast && it.packet_size < SizeUcast) begin
        st = STAT_HDR_SHORT;
      end else if (ucast && {it.hdr_byte2, it.hdr_byte1} != node_addr) begin
        st = STAT_NOT_ADDR;
      end else begin
        accepted_pkts = accepted_pkts + 32'd1;
        fid  = ucast ? {it.hdr_byte4, it.hdr_byte3} : {it.hdr_byte2, it.hdr_byte1};
        sidx = ucast ? it.hdr_byte5 : it.hdr_byte3;
        stot = ucast ? it.hdr_byte6 : it.hdr_byte4;
        if (it.msg_type == MsgSem) begin
          semantic_pkts = semantic_pkts + 32'd1;
          st = STAT_SEMANTIC;
        end else if (!ucast && it.packet_size < SizeBcast) begin
          st = STAT_HDR_SHORT;
        end else if (stot == 0 || stot > MaxSubpackets || sidx >= stot) begin
          st = STAT_BAD_SUB;
        end else begin
          valid_subs = valid_subs + 32'd1;
          slot = int'(fid) % FragmentSlots;
          if (direct_done[slot]) begin
            st = STAT_ALREADY;
          end else begin
            arrival_bits[slot][sidx[SidxW-1:0]] = 1'b1;
            ones = 0;
            for (int b = 0; b < MaxSubpackets; b++) ones += int'(arrival_bits[slot][b]);
            if (ones >= int'(stot)) begin
              direct_done[slot]   = 1'b1;
              distinct_seen[slot] = 1'b1;
              arrival_bits[slot]  = '0;
              st = STAT_COMPLETED;
            end else begin
              st = STAT_RECORDED;
            end
          end
        end
      end
    end
    rep.status           = st;
    rep.frag             = fid;
    rep.gain             = gain;
    rep.rx_total         = accepted_pkts;
    rep.semantic_count   = semantic_pkts;
    rep.data_sub_count   = valid_subs;
    rep.coop_gain_total  = coop_total;
    rep.coop_round_count = coop_rounds;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int s = 0; s < FragmentSlots; s++) begin
        arrival_bits[s]  = '0;
        direct_done[s]   = 1'b0;
        distinct_seen[s] = 1'b0;
      end
      accepted_pkts = '0;
      semantic_pkts = '0;
      valid_subs    = '0;
      coop_total    = '0;
      coop_rounds   = '0;
      merge_acc     = '0;
      node_addr     = '0;
      pending_reports.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
    end else begin
      // result side first: a result never belongs to an item taken at the same edge
      if (pop_i && !empty_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d fragment %0h",
                   $time, status_i, fragment_id_i);
          fail_count_o++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("fragment_id", 32'(want.frag), 32'(fragment_id_i));
          check_field("merge_gain", 32'(want.gain), 32'(merge_gain_i));
          check_field("rx_total", want.rx_total, rx_total_i);
          check_field("semantic_count", want.semantic_count, semantic_count_i);
          check_field("data_sub_count", want.data_sub_count, data_sub_count_i);
          check_field("coop_gain_total", want.coop_gain_total, coop_gain_total_i);
          check_field("coop_round_count", want.coop_round_count, coop_round_count_i);
        end
      end
      if (push_i && !full_i) begin
        if (track_reassembly(item_i, want)) pending_reports.push_back(want);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == NodeAddrOffset) begin
        node_addr = pwdata_i[15:0];
      end
      pending_count_o = pending_reports.size();
    end
  end

endmodule

FILE: tb/sv/tb_fragment_reassembly_tracker.sv
// tb_fragment_reassembly_tracker: stimulus, flow control and verdict for the tracker
// drives directed and random packet and merge transactions over several node addresses
// depends on frt_pkg, fragment_reassembly_tracker and frt_reassembly_checker
`timescale 1ns / 1ps

module tb_fragment_reassembly_tracker;
  import frt_pkg::*;

  localparam logic [2:0] NodeAddrOffset = 3'd0;
  localparam int WatchdogLimit = 200000;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 300;
  localparam int PhaseItems    = 340;

  typedef enum int {
    POP_STEADY,
    POP_RANDOM,
    POP_SPARSE
  } pop_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  pkt_t        stim_item;
  logic        empty;
  logic        pop;
  logic [3:0]  status;
  logic [15:0] fragment_id;
  logic [16:0] merge_gain;
  logic [31:0] rx_total;
  logic [31:0] semantic_count;
  logic [31:0] data_sub_count;
  logic [31:0] coop_gain_total;
  logic [31:0] coop_round_count;
  int          fail_count;
  int          pending_count;
  logic        hold_window;
  int          burst_left;
  int          idle_cycles;

  fragment_reassembly_tracker uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .full              (full),
    .operation_i       (stim_item.operation),
    .packet_size_i     (stim_item.packet_size),
    .msg_type_i        (stim_item.msg_type),
    .hdr_byte1_i       (stim_item.hdr_byte1),
    .hdr_byte2_i       (stim_item.hdr_byte2),
    .hdr_byte3_i       (stim_item.hdr_byte3),
    .hdr_byte4_i       (stim_item.hdr_byte4),
    .hdr_byte5_i       (stim_item.hdr_byte5),
    .hdr_byte6_i       (stim_item.hdr_byte6),
    .coop_fragment_i   (stim_item.coop_fragment),
    .coop_last_i       (stim_item.coop_last),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status),
    .fragment_id_o     (fragment_id),
    .merge_gain_o      (merge_gain),
    .rx_total_o        (rx_total),
    .semantic_count_o  (semantic_count),
    .data_sub_count_o  (data_sub_count),
    .coop_gain_total_o (coop_gain_total),
    .coop_round_count_o(coop_round_count)
  );

  frt_reassembly_checker #(
    .NodeAddrOffset(NodeAddrOffset)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .push_i            (push),
    .full_i            (full),
    .item_i            (stim_item),
    .empty_i           (empty),
    .pop_i             (pop),
    .status_i          (status),
    .fragment_id_i     (fragment_id),
    .merge_gain_i      (merge_gain),
    .rx_total_i        (rx_total),
    .semantic_count_i  (semantic_count),
    .data_sub_count_i  (data_sub_count),
    .coop_gain_total_i (coop_gain_total),
    .coop_round_count_i(coop_round_count),
    .fail_count_o      (fail_count),
    .pending_count_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic pkt_t header_item(input logic [15:0] size, input logic [7:0] b0,
                                       input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [7:0] b3, input logic [7:0] b4,
                                       input logic [7:0] b5, input logic [7:0] b6);
    pkt_t it;
    it = '0;
    it.packet_size = size;
    it.msg_type    = b0;
    it.hdr_byte1   = b1;
    it.hdr_byte2   = b2;
    it.hdr_byte3   = b3;
    it.hdr_byte4   = b4;
    it.hdr_byte5   = b5;
    it.hdr_byte6   = b6;
    return it;
  endfunction

  function automatic pkt_t merge_item(input logic [15:0] id, input logic last);
    pkt_t it;
    it = '0;
    it.operation     = 1'b1;
    it.coop_fragment = id;
    it.coop_last     = last;
    return it;
  endfunction

  // mostly well-formed data packets on a small pool of fragments so that bitmaps
  // fill up and complete, the rest semantic packets, merges, broken headers and noise
  function automatic pkt_t random_item(input logic [15:0] node, input logic [15:0] base);
    pkt_t        it;
    logic [95:0] noise;
    logic [15:0] fid;
    logic [7:0]  tot;
    logic [15:0] size;
    int          pick;
    noise = {$urandom, $urandom, $urandom};
    it    = noise[$bits(pkt_t)-1:0];
    pick  = int'($urandom_range(0, 99));
    fid   = ($urandom_range(0, 2) == 0) ? 16'($urandom) : base + 16'($urandom_range(0, 15));
    tot   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, MaxSubpackets))
                                         : 8'($urandom_range(1, 4));
    size  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 65535))
                                         : 16'($urandom_range(7, 80));
    if (pick < 35) begin
      it.operation   = 1'b0;
      it.packet_size = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(5, 6)) : size;
      it.msg_type    = MsgBcast;
      it.hdr_byte1   = fid[7:0];
      it.hdr_byte2   = fid[15:8];
      it.hdr_byte3   = 8'($urandom_range(0, int'(tot) - 1));
      it.hdr_byte4   = tot;
    end else if (pick < 55) begin
      it.operation   = 1'b0;
      it.packet_size = size;
      it.msg_type    = MsgUcast;
      it.hdr_byte1   = node[7:0];
      it.hdr_byte2   = node[15:8];
      it.hdr_byte3   = fid[7:0];
      it.hdr_byte4   = fid[15:8];
      it.hdr_byte5   = 8'($urandom_range(0, int'(tot) - 1));
      it.hdr_byte6   = tot;
    end else if (pick < 63) begin
      it.operation   = 1'b0;
      it.packet_size = 16'($urandom_range(4, 80));
      it.msg_type    = MsgSem;
    end else if (pick < 80) begin
      it.operation     = 1'b1;
      it.coop_fragment = ($urandom_range(0, 1) == 0) ? fid : base + 16'($urandom_range(0, 31));
      it.coop_last     = ($urandom_range(0, 3) == 0);
    end else if (pick < 92) begin
      it.operation   = 1'b0;
      it.packet_size = 16'($urandom_range(0, 9));
      it.msg_type    = 8'($urandom_range(int'(MsgBcast), int'(MsgUcast)));
      if ($urandom_range(0, 1) == 0) begin
        it.hdr_byte1 = node[7:0];
        it.hdr_byte2 = node[15:8];
      end
    end
    return it;
  endfunction

  task automatic send_item(input pkt_t it);
    stim_item <= it;
    push      <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(5, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      burst_left = int'($urandom_range(1, 24));
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_node_address(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NodeAddrOffset;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver: own stall pattern, plus one long hold-off to fill the block
  initial begin
    pop_mode_e mode;
    int        mode_left;
    int        hold_left;
    int        results_seen;
    int        hold_at;
    bit        held;
    mode         = POP_STEADY;
    mode_left    = 0;
    hold_left    = 0;
    results_seen = 0;
    hold_at      = -1;
    held         = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) results_seen++;
      if (mode_left == 0) begin
        mode      = pop_mode_e'($urandom_range(0, 2));
        mode_left = int'($urandom_range(10, 60));
      end
      mode_left--;
      if (hold_window && hold_at < 0) hold_at = results_seen + 30;
      if (!held && hold_at >= 0 && results_seen >= hold_at) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          POP_STEADY: pop <= 1'b1;
          POP_RANDOM: pop <= 1'($urandom_range(0, 1));
          default:    pop <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cur_node;
    logic [15:0] hot_base;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    push        <= 1'b0;
    stim_item   <= '0;
    hold_window <= 1'b0;
    burst_left  = int'($urandom_range(1, 24));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    cur_node = 16'hA5C3;
    write_node_address(cur_node);

    // short, foreign types, header-short cases and unicast filtering
    send_item(header_item(16'd0, MsgBcast, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66));
    send_item(header_item(16'd3, MsgBcast, 8'h11, 8'h22, 8'h00, 8'h01, 8'h00, 8'h00));
    send_item(header_item(16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(header_item(16'd16, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00));
    send_item(header_item(16'd4, MsgSem, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(header_item(16'd4, MsgBcast, 8'hCD, 8'hAB, 8'h00, 8'h01, 8'h00, 8'h00));
    send_item(header_item(16'd6, MsgUcast, 8'hC3, 8'hA5, 8'h01, 8'h00, 8'h00, 8'h01));
    send_item(header_item(16'd7, MsgUcast, 8'hC2, 8'hA5, 8'h01, 8'h00, 8'h00, 8'h01));
    send_item(header_item(16'd7, MsgUcast, 8'hC3, 8'hA5, 8'hFF, 8'hFF, 8'h00, 8'h01));
    // bad sub-packet totals and indexes
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'h00, 8'd33, 8'h00, 8'h00));
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'd4, 8'd4, 8'h00, 8'h00));
    // repeated index, then a smaller total completes the fragment
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'd31, 8'd32, 8'h00, 8'h00));
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'd31, 8'd32, 8'h00, 8'h00));
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'd0, 8'd2, 8'h00, 8'h00));
    send_item(header_item(16'd5, MsgBcast, 8'h00, 8'h00, 8'd0, 8'd2, 8'h00, 8'h00));
    send_item(header_item(16'hFFFF, MsgUcast, 8'hC3, 8'hA5, 8'h01, 8'h00, 8'hFF, 8'hFF));
    // merge set with a packet inside, a duplicate id and ids already distinct
    send_item(merge_item(16'h0000, 1'b0));
    send_item(merge_item(16'h7777, 1'b0));
    send_item(header_item(16'd9, MsgSem, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(merge_item(16'h7777, 1'b0));
    send_item(merge_item(16'hFFFF, 1'b1));
    send_item(merge_item(16'hFFFF, 1'b1));
    send_item(merge_item(16'h8001, 1'b1));
    send_item(header_item(16'd7, MsgBcast, 8'h78, 8'h56, 8'h00, 8'h01, 8'hAA, 8'h55));

    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0:       cur_node = 16'h0000;
        1:       cur_node = 16'hFFFF;
        3:       cur_node = 16'h00FF;
        default: cur_node = 16'($urandom);
      endcase
      write_node_address(cur_node);
      if (ph == 2) hold_window <= 1'b1;
      hot_base = 16'($urandom);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 39) hot_base = 16'($urandom);
        send_item(random_item(cur_node, hot_base));
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
